// ===== hdl/sru_pkg.sv =====
// sru_pkg: shared types and constants of the status register unit.
// Holds operation codes, status word bit masks and the result record.
// No dependencies.
package sru_pkg;

    typedef enum logic [2:0] {
        CMD_MRS    = 3'd0,
        CMD_MSR    = 3'd1,
        CMD_SETEND = 3'd2,
        CMD_CPS    = 3'd3,
        CMD_SVC    = 3'd4
    } sru_cmd_t;

    localparam logic [4:0]  MODE_SVC   = 5'h13;
    localparam logic [4:0]  MODE_USER  = 5'h10;
    localparam logic [31:0] SVC_VECTOR = 32'h0000_0008;
    localparam logic [31:0] RESET_PSR  = 32'h0000_01D3;
    localparam logic [3:0]  LINK_REG   = 4'd14;
    localparam logic [3:0]  PC_REG     = 4'd15;

    localparam logic [31:0] MASK_MODE  = 32'h0000_001F;
    localparam logic [31:0] BIT_E      = 32'h0000_0200;
    localparam logic [31:0] BIT_A      = 32'h0000_0100;
    localparam logic [31:0] BIT_I      = 32'h0000_0080;
    localparam logic [31:0] BIT_F      = 32'h0000_0040;
    localparam logic [31:0] BIT_T      = 32'h0000_0020;
    localparam logic [31:0] MASK_GE    = 32'h000F_0000;
    localparam logic [31:0] MASK_FLAGS = 32'hF800_0000;
    localparam logic [31:0] MASK_IT    = 32'h0600_FC00;
    localparam logic [31:0] MASK_CTRL  = BIT_E | BIT_A | BIT_I | BIT_F | MASK_MODE;
    localparam logic [31:0] MASK_AIF   = BIT_A | BIT_I | BIT_F;

    // Packed so that reg_write lands in bit 0 of the output tdata.
    typedef struct packed {
        logic [31:0] saved_status_now;
        logic [31:0] status_now;
        logic [31:0] redirect_target;
        logic        redirect;
        logic [31:0] reg_value;
        logic [3:0]  reg_index;
        logic        reg_write;
    } sru_result_t;

    localparam int RESULT_BITS = $bits(sru_result_t);
    localparam int OUT_BYTES   = (RESULT_BITS + 7) / 8;
    localparam int IN_BITS     = 3 + 32 + 32 + 32;
    localparam int IN_BYTES    = (IN_BITS + 7) / 8;

endpackage

// ===== hdl/sru_exec.sv =====
// sru_exec: combinational execution of one system instruction.
// Computes the result record and next status words from the current ones.
// Depends on sru_pkg.
module sru_exec (
    input  logic [2:0]          cmd,
    input  logic [31:0]         instr_word,
    input  logic [31:0]         reg_operand,
    input  logic [31:0]         next_pc,
    input  logic [31:0]         cpsr,
    input  logic [31:0]         spsr,
    output sru_pkg::sru_result_t result
);
    import sru_pkg::*;

    logic [4:0]  rot;
    logic [63:0] rot_wide;
    logic [31:0] operand;
    logic [31:0] write_mask;
    logic [31:0] cpsr_next;
    logic [31:0] spsr_next;
    logic        use_spsr;
    logic [3:0]  rd;

    // Rotated immediate: imm8 rotated right by twice the rotate field.
    assign rot      = {instr_word[11:8], 1'b0};
    assign rot_wide = {24'd0, instr_word[7:0], 24'd0, instr_word[7:0]} >> rot;
    assign operand  = instr_word[25] ? rot_wide[31:0] : reg_operand;

    assign write_mask = (instr_word[16] ? MASK_CTRL  : 32'd0)
                      | (instr_word[18] ? MASK_GE    : 32'd0)
                      | (instr_word[19] ? MASK_FLAGS : 32'd0);

    assign use_spsr = instr_word[22];
    assign rd       = instr_word[15:12];

    always_comb
    begin
        cpsr_next = cpsr;
        spsr_next = spsr;
        result    = '0;
        unique case (cmd)
            CMD_MRS:
            begin
                if (rd != PC_REG)
                begin
                    result.reg_write = 1'b1;
                    result.reg_index = rd;
                    result.reg_value = use_spsr ? spsr : cpsr;
                end
            end
            CMD_MSR:
            begin
                if (use_spsr)
                begin
                    if (cpsr[4:0] != MODE_USER)
                        spsr_next = (spsr & ~write_mask) | (operand & write_mask);
                end
                else
                begin
                    cpsr_next = (cpsr & ~write_mask) | (operand & write_mask);
                end
            end
            CMD_SETEND:
            begin
                cpsr_next = instr_word[9] ? (cpsr | BIT_E) : (cpsr & ~BIT_E);
            end
            CMD_CPS:
            begin
                cpsr_next = instr_word[18] ? (cpsr | (instr_word & MASK_AIF))
                                           : (cpsr & ~(instr_word & MASK_AIF));
                if (instr_word[17])
                    cpsr_next = (cpsr_next & ~MASK_MODE) | (instr_word & MASK_MODE);
            end
            CMD_SVC:
            begin
                spsr_next = cpsr;
                cpsr_next = ((cpsr & ~(MASK_MODE | BIT_T | MASK_IT)) | BIT_I)
                          | {27'd0, MODE_SVC};
                result.reg_write       = 1'b1;
                result.reg_index       = LINK_REG;
                result.reg_value       = next_pc;
                result.redirect        = 1'b1;
                result.redirect_target = SVC_VECTOR;
            end
            default:
            begin
                cpsr_next = cpsr;
            end
        endcase
        result.status_now       = cpsr_next;
        result.saved_status_now = spsr_next;
    end

endmodule

// ===== hdl/status_register_unit.sv =====
// status_register_unit: top level of the program status word unit.
// Input register, status word registers and result register around sru_exec.
// Depends on sru_pkg and sru_exec.

// The unit holds the current (CPSR) and saved (SPSR) program status words and
// executes one system instruction per transaction: MRS, MSR, SETEND, CPS and
// SVC. Every input transaction produces exactly one result transaction that
// carries the register write, the pc redirect and both status words as they
// stand after the instruction. Throughput is one transaction per clock while
// the result side is not stalled; an accepted instruction waits in the input
// register, executes there and is then held in the result register. The status
// words update in the same cycle an instruction moves from the input register
// to the result register, so the next instruction sees them immediately.
// After reset CPSR is 0x000001D3 (supervisor mode, IRQ and FIQ masked) and
// SPSR is zero. Unused operation codes leave the state unchanged.
module status_register_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // cmd[2:0], instr_word[34:3], reg_operand[66:35], next_pc[98:67], zero pad
    input  logic [8*sru_pkg::IN_BYTES-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // reg_write[0], reg_index[4:1], reg_value[36:5], redirect[37],
    // redirect_target[69:38], status_now[101:70], saved_status_now[133:102]
    output logic [8*sru_pkg::OUT_BYTES-1:0]  m_axis_tdata
);
    import sru_pkg::*;

    logic        in_valid_reg;
    logic [2:0]  cmd_reg;
    logic [31:0] word_reg;
    logic [31:0] operand_reg;
    logic [31:0] npc_reg;

    logic [31:0] cpsr_reg;
    logic [31:0] spsr_reg;

    logic        out_valid_reg;
    sru_result_t out_reg;
    sru_result_t exec_result;

    logic        advance;

    // Move the held instruction forward when the result slot is free or drains.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register: hold one instruction until it can execute.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cmd_reg     <= s_axis_tdata[2:0];
            word_reg    <= s_axis_tdata[34:3];
            operand_reg <= s_axis_tdata[66:35];
            npc_reg     <= s_axis_tdata[98:67];
        end
    end

    sru_exec u_exec (
        .cmd         (cmd_reg),
        .instr_word  (word_reg),
        .reg_operand (operand_reg),
        .next_pc     (npc_reg),
        .cpsr        (cpsr_reg),
        .spsr        (spsr_reg),
        .result      (exec_result)
    );

    // Status words: commit the new values as the instruction executes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpsr_reg <= RESET_PSR;
            spsr_reg <= '0;
        end
        else if (advance)
        begin
            cpsr_reg <= exec_result.status_now;
            spsr_reg <= exec_result.saved_status_now;
        end
    end

    // Result register: valid drops only when taken with nothing behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= exec_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(8*OUT_BYTES - RESULT_BITS){1'b0}}, out_reg};

endmodule

// ===== hdl/sru_checker.sv =====
// sru_checker: port-level assertions for status_register_unit.
// Bound to the top level at the end of this file.
// Depends on sru_pkg.
module sru_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [8*sru_pkg::OUT_BYTES-1:0]  m_axis_tdata
);
    import sru_pkg::*;

    sru_result_t res;

    assign res = m_axis_tdata[RESULT_BITS-1:0];

    // No result transaction while reset is held.
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

    // Hold a stalled result.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // A supervisor call writes the link register and enters supervisor mode.
    a_svc_entry: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.redirect |->
            res.reg_write && res.reg_index == LINK_REG
            && res.redirect_target == SVC_VECTOR
            && res.status_now[4:0] == MODE_SVC
            && (res.status_now & (BIT_T | MASK_IT)) == 32'd0
            && (res.status_now & BIT_I) != 32'd0)
        else $error("bad supervisor call result");

    // Drop the redirect target whenever no redirect is signaled.
    a_no_redirect: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !res.redirect |-> res.redirect_target == 32'd0)
        else $error("redirect target without redirect");

endmodule

bind status_register_unit sru_checker u_sru_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/testbench.sv =====
// testbench: self-checking bench for status_register_unit.
// Predicts every result from its own model of CPSR and SPSR and checks it field by field.
// Depends on sru_pkg and the status_register_unit RTL.
`timescale 1ns / 1ps

module testbench;
    import sru_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int TAIL_CYCLES   = 8;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 96;
    localparam int HOLD_BURST    = 24;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int IN_W          = 8 * IN_BYTES;

    // bit positions of the MSR field mask {f s x c}
    localparam int FIELD_C = 0;
    localparam int FIELD_S = 2;
    localparam int FIELD_F = 3;

    // codes above the last defined operation must leave the state alone
    localparam logic [2:0] CMD_LAST_USED = CMD_SVC;

    // Scoreboard: keeps a private copy of both status words, predicts each
    // result when a transaction is accepted and checks results in order.
    class psr_scoreboard;
        logic [31:0] cpsr;
        logic [31:0] spsr;
        sru_result_t pending_results[$];
        int          errors;

        function new();
            cpsr   = RESET_PSR;
            spsr   = '0;
            errors = 0;
        endfunction

        function logic [31:0] msr_operand(logic [31:0] word, logic [31:0] rm);
            logic [31:0] imm;
            logic [5:0]  rot;
            if (!word[25])
                return rm;
            imm = {24'b0, word[7:0]};
            rot = {1'b0, word[11:8], 1'b0};
            if (rot == 6'd0)
                return imm;
            return (imm >> rot) | (imm << (6'd32 - rot));
        endfunction

        // control keeps T; the x field writes nothing
        function logic [31:0] write_fields(logic [31:0] psr, logic [31:0] v, logic [3:0] mask);
            if (mask[FIELD_C])
                psr = (psr & ~MASK_CTRL) | (v & MASK_CTRL);
            if (mask[FIELD_S])
                psr = (psr & ~MASK_GE) | (v & MASK_GE);
            if (mask[FIELD_F])
                psr = (psr & ~MASK_FLAGS) | (v & MASK_FLAGS);
            return psr;
        endfunction

        function void note_instruction(logic [2:0] cmd, logic [31:0] word,
                                       logic [31:0] rm, logic [31:0] npc);
            sru_result_t r;
            logic [31:0] operand;
            logic [31:0] aif;
            r = '0;
            unique case (cmd)
                CMD_MRS:
                begin
                    if (word[15:12] != PC_REG)
                    begin
                        r.reg_write = 1'b1;
                        r.reg_index = word[15:12];
                        r.reg_value = word[22] ? spsr : cpsr;
                    end
                end
                CMD_MSR:
                begin
                    operand = msr_operand(word, rm);
                    if (word[22])
                    begin
                        // user mode has no SPSR: drop the write
                        if (cpsr[4:0] != MODE_USER)
                            spsr = write_fields(spsr, operand, word[19:16]);
                    end
                    else
                        cpsr = write_fields(cpsr, operand, word[19:16]);
                end
                CMD_SETEND:
                    cpsr = word[9] ? (cpsr | BIT_E) : (cpsr & ~BIT_E);
                CMD_CPS:
                begin
                    aif  = word & MASK_AIF;
                    cpsr = word[18] ? (cpsr | aif) : (cpsr & ~aif);
                    if (word[17])
                        cpsr = (cpsr & ~MASK_MODE) | (word & MASK_MODE);
                end
                CMD_SVC:
                begin
                    spsr = cpsr;
                    cpsr = (cpsr & ~(MASK_MODE | BIT_T | MASK_IT)) | 32'(MODE_SVC) | BIT_I;
                    r.reg_write       = 1'b1;
                    r.reg_index       = LINK_REG;
                    r.reg_value       = npc;
                    r.redirect        = 1'b1;
                    r.redirect_target = SVC_VECTOR;
                end
                default: ;
            endcase
            r.status_now       = cpsr;
            r.saved_status_now = spsr;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(sru_result_t got);
            sru_result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("reg_write", 32'(want.reg_write), 32'(got.reg_write));
            compare_field("reg_index", 32'(want.reg_index), 32'(got.reg_index));
            compare_field("reg_value", want.reg_value, got.reg_value);
            compare_field("redirect", 32'(want.redirect), 32'(got.redirect));
            compare_field("redirect_target", want.redirect_target, got.redirect_target);
            compare_field("status_now", want.status_now, got.status_now);
            compare_field("saved_status_now", want.saved_status_now, got.saved_status_now);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    // cmd, instr_word, reg_operand, next_pc from the lowest bit up, zero pad
    logic [8*IN_BYTES-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    // reg_write, reg_index, reg_value, redirect, redirect_target,
    // status_now, saved_status_now from the lowest bit up
    logic [8*OUT_BYTES-1:0] m_axis_tdata;

    psr_scoreboard sb = new();
    int  cycle_count = 0;
    bit  rx_stalls   = 1'b0;   // receiver follows its stall pattern when set
    bit  rx_hold_req = 1'b0;   // one long receiver hold-off when set

    status_register_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #CLK_HALF clk = ~clk;

    // Watch both sides at the rising edge; note the input before checking any
    // result that is taken at the same edge.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_instruction(s_axis_tdata[2:0], s_axis_tdata[34:3],
                                s_axis_tdata[66:35], s_axis_tdata[98:67]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(sru_result_t'(m_axis_tdata[RESULT_BITS-1:0]));
    end

    // Hard stop in case a handshake never completes.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Receiver: ready in random runs separated by random stalls, always ready
    // when stalls are off, and one long hold-off on request.
    initial
    begin : receiver
        int  run_left;
        bit  ready_phase;
        m_axis_tready = 1'b0;
        run_left      = 0;
        ready_phase   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                m_axis_tready <= 1'b0;
                rx_hold_req = 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!rx_stalls)
                m_axis_tready <= 1'b1;
            else
            begin
                if (run_left == 0)
                begin
                    ready_phase = !ready_phase;
                    run_left = ready_phase ? $urandom_range(1, 10) : $urandom_range(1, 4);
                end
                run_left--;
                m_axis_tready <= ready_phase;
            end
        end
    end

    // All driving tasks start and end at a falling edge.
    task automatic send_instruction(input logic [2:0] cmd, input logic [31:0] word,
                                    input logic [31:0] rm, input logic [31:0] npc);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({npc, rm, word, cmd});
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic idle_cycles(input int n);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= IN_W'({$urandom, $urandom, $urandom, $urandom});
        repeat (n) @(negedge clk);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] mrs_word(bit use_spsr, logic [3:0] rd);
        return {9'b0, use_spsr, 6'b0, rd, 12'b0};
    endfunction

    function automatic logic [31:0] msr_word(bit imm_form, bit use_spsr, logic [3:0] mask,
                                             logic [3:0] rot, logic [7:0] imm8);
        return {6'b0, imm_form, 2'b0, use_spsr, 2'b0, mask, 4'b0, rot, imm8};
    endfunction

    function automatic logic [31:0] cps_word(bit disable_aif, bit set_mode,
                                             logic [2:0] aif, logic [4:0] mode);
        return {13'b0, disable_aif, set_mode, 8'b0, aif, 1'b0, mode};
    endfunction

    function automatic logic [31:0] random_extreme();
        unique case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Random instruction: fully random words reach every field; CPS is
    // steered toward mode changes, user mode in particular, so the SPSR
    // write drop gets exercised.
    task automatic send_random_instruction();
        logic [2:0]  cmd;
        logic [31:0] word;
        if ($urandom_range(0, 49) == 0)
            cmd = CMD_LAST_USED + 3'($urandom_range(1, 3));
        else
            cmd = 3'($urandom_range(CMD_MRS, CMD_SVC));
        word = $urandom;
        if (cmd == CMD_CPS && $urandom_range(0, 1))
        begin
            word[17]  = 1'b1;
            word[4:0] = $urandom_range(0, 1) ? MODE_USER : 5'($urandom);
        end
        send_instruction(cmd, word, random_extreme(), random_extreme());
    endtask

    initial
    begin : stimulus
        int sent;
        int burst;
        bit tx_gaps;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: read the reset words, skip the pc destination.
        send_instruction(CMD_MRS, '0, '0, '0);
        send_instruction(CMD_MRS, '1, '1, '1);
        send_instruction(CMD_MRS, mrs_word(1'b1, LINK_REG), '0, '0);
        // MSR register form, every field at once, operand all ones.
        send_instruction(CMD_MSR, msr_word(1'b0, 1'b0, 4'hF, 4'h0, 8'h00), '1, '0);
        // MSR immediate: no rotation, rotate by 8 into the flags, rotate by 30.
        send_instruction(CMD_MSR, msr_word(1'b1, 1'b0, 4'h1, 4'h0, 8'hD3), '0, '0);
        send_instruction(CMD_MSR, msr_word(1'b1, 1'b0, 4'h8, 4'h4, 8'hF8), '0, '0);
        send_instruction(CMD_MSR, msr_word(1'b1, 1'b0, 4'h4, 4'hF, 8'hFF), '0, '0);
        // x field alone writes nothing.
        send_instruction(CMD_MSR, msr_word(1'b0, 1'b0, 4'h2, 4'h0, 8'h00), '1, '0);
        // SPSR writes in a privileged mode.
        send_instruction(CMD_MSR, msr_word(1'b0, 1'b1, 4'hF, 4'h0, 8'h00), '1, '0);
        send_instruction(CMD_MSR, msr_word(1'b1, 1'b1, 4'h9, 4'h1, 8'h3C), '0, '0);
        send_instruction(CMD_MRS, mrs_word(1'b1, 4'd0), '0, '0);
        // Endianness both ways.
        send_instruction(CMD_SETEND, BIT_E, '0, '0);
        send_instruction(CMD_SETEND, '0, '1, '1);
        // CPS: mask all, unmask all, then drop to user mode.
        send_instruction(CMD_CPS, cps_word(1'b1, 1'b0, 3'b111, 5'h00), '0, '0);
        send_instruction(CMD_CPS, cps_word(1'b0, 1'b0, 3'b111, 5'h1F), '0, '0);
        send_instruction(CMD_CPS, cps_word(1'b1, 1'b1, 3'b010, MODE_USER), '0, '0);
        // In user mode the SPSR write is dropped.
        send_instruction(CMD_MSR, msr_word(1'b0, 1'b1, 4'hF, 4'h0, 8'h00), '0, '0);
        send_instruction(CMD_MRS, mrs_word(1'b1, 4'd7), '0, '0);
        // Supervisor calls with extreme links.
        send_instruction(CMD_SVC, '0, '0, '1);
        send_instruction(CMD_SVC, '1, '1, '0);
        // Undefined codes touch nothing.
        send_instruction(CMD_LAST_USED + 3'd1, '1, '1, '1);
        send_instruction(CMD_LAST_USED + 3'd2, '0, '0, '0);
        send_instruction(CMD_LAST_USED + 3'd3, '1, '1, '1);
        send_instruction(CMD_MRS, mrs_word(1'b0, 4'd3), '0, '0);
        wait_for_results();

        // Random phases: vary receiver stalls and sender gaps per phase.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            rx_stalls = ($urandom_range(0, 3) != 0);
            tx_gaps   = ($urandom_range(0, 3) != 0);
            sent = 0;
            // Hold off the receiver while items keep coming back to back.
            if (phase % 4 == 2)
            begin
                rx_hold_req = 1'b1;
                repeat (HOLD_BURST) send_random_instruction();
                sent = HOLD_BURST;
            end
            while (sent < PHASE_ITEMS)
            begin
                burst = $urandom_range(1, 20);
                for (int k = 0; k < burst && sent < PHASE_ITEMS; k++)
                begin
                    send_random_instruction();
                    sent++;
                end
                if (tx_gaps)
                    idle_cycles($urandom_range(1, 6));
            end
            // Pause the sender until everything has come back.
            if (phase % 3 == 1)
                wait_for_results();
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/sru_pkg.sv
hdl/sru_exec.sv
hdl/status_register_unit.sv
hdl/sru_checker.sv
tb/testbench.sv
